@@ sv/bdq_pkg.sv @@
// Shared widths, types and command and status codes for the bounded deque with key search.
`default_nettype none

package bdq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int CMD_W = 3;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int POS_W = 4;
    localparam int OCC_W = 5;

    typedef logic [CMD_W-1:0]        t_cmd;
    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [ST_W-1:0]         t_status;
    typedef logic [POS_W-1:0]        t_pos;
    typedef logic [OCC_W-1:0]        t_occ;

    localparam t_cmd CMD_PUSH_FRONT = 3'd0;
    localparam t_cmd CMD_PUSH_BACK  = 3'd1;
    localparam t_cmd CMD_SEARCH     = 3'd2;
    localparam t_cmd CMD_POP_FRONT  = 3'd3;
    localparam t_cmd CMD_POP_BACK   = 3'd4;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_EMPTY    = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_NOTFOUND = 2'd3;

endpackage

`default_nettype wire

@@ sv/bdq_if.sv @@
// Request and response channel interfaces of the bounded deque with key search.
`default_nettype none

interface bdq_cmd_if;
    logic           valid;
    logic           ready;
    bdq_pkg::t_cmd  command;
    bdq_pkg::t_val  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface bdq_res_if;
    logic             valid;
    logic             ready;
    bdq_pkg::t_status status;
    bdq_pkg::t_val    result_value;
    bdq_pkg::t_pos    position;
    bdq_pkg::t_occ    occupancy;

    modport source (output valid, output status, output result_value, output position,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input result_value, input position,
                    input occupancy, output ready);
endinterface

`default_nettype wire

@@ sv/bounded_deque_with_key_search_core.sv @@
// Bounded deque with key search: ring store, command sequencer and result register.
//
// Each request on i_cmd carries a command and a value; each one produces exactly one
// response on o_res with a status, a value, a position and the occupancy after the
// command. The entries sit in a ring memory of DEPTH words with a write port and a
// registered read port. A request is taken only while the sequencer is idle.
// Inserts, unused codes and requests that fail at once pass through the execute
// and done states to the response register; removals add a read-wait state as the
// memory read is registered. A search reads one entry per cycle through a single
// comparator and stops at the first match or after the last held entry.
// The next request is taken in the cycle after the response is loaded, even while
// that response still waits on o_res. If the receiver stalls and a second response
// is ready, the sequencer holds it until the first one is taken.
// Synchronous reset empties the deque at once; memory contents are not cleared and
// are never used before they are written.
`default_nettype none

module bounded_deque_with_key_search_core #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdq_cmd_if.sink     i_cmd,
    bdq_res_if.source   o_res
);
    import bdq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_EXT  = (AW+1)'(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_RDWAIT = 5'b00100,
        S_SEARCH = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    function automatic logic [AW-1:0] f_wrap(input logic [AW:0] sum);
        if (sum >= DEPTH_EXT) begin
            return AW'(sum - DEPTH_EXT);
        end
        return sum[AW-1:0];
    endfunction

    logic [VAL_W-1:0] mem [DEPTH];

    t_state          r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    t_val            r_key, n_key;
    logic [AW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_slot, n_slot;
    t_status         r_st, n_st;
    t_val            r_rval, n_rval;
    logic [AW-1:0]   r_pos, n_pos;
    logic [VAL_W-1:0] r_rd_data;

    logic            r_out_valid, n_out_valid;
    t_status         r_out_st;
    t_val            r_out_val;
    t_pos            r_out_pos;
    t_occ            r_out_occ;

    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [AW-1:0]   w_raddr;
    logic            w_load;
    logic            w_full;
    logic            w_empty;
    logic            w_hit;
    logic            w_last;
    logic [AW-1:0]   w_prev_front;
    logic [AW-1:0]   w_next_front;
    logic [AW-1:0]   w_next_slot;
    logic [AW-1:0]   w_back_slot;
    logic [AW-1:0]   w_tail_slot;
    logic [CW-1:0]   w_idx_inc;

    assign w_full       = (r_count == FULL_COUNT);
    assign w_empty      = (r_count == '0);
    assign w_hit        = (t_val'(r_rd_data) == r_key);
    assign w_idx_inc    = CW'(r_idx) + CW'(1);
    assign w_last       = (w_idx_inc == r_count);
    assign w_prev_front = (r_front == '0) ? LAST_SLOT : r_front - 1'b1;
    assign w_next_front = f_wrap({1'b0, r_front} + (AW+1)'(1));
    assign w_next_slot  = f_wrap({1'b0, r_slot} + (AW+1)'(1));
    assign w_back_slot  = f_wrap({1'b0, r_front} + (AW+1)'(r_count));
    assign w_tail_slot  = f_wrap({1'b0, r_front} + (AW+1)'(r_count - CW'(1)));

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_slot      = r_slot;
        n_st        = r_st;
        n_rval      = r_rval;
        n_pos       = r_pos;
        w_we        = 1'b0;
        w_waddr     = r_front;
        w_raddr     = r_slot;
        w_load      = 1'b0;
        n_out_valid = r_out_valid && !o_res.ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd   = i_cmd.command;
                    n_key   = i_cmd.value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_st    = ST_OK;
                n_rval  = '0;
                n_pos   = '0;
                n_state = S_DONE;
                unique case (r_cmd)
                    CMD_PUSH_FRONT: begin
                        if (w_full) begin
                            n_st = ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = w_prev_front;
                            n_front = w_prev_front;
                            n_count = r_count + CW'(1);
                        end
                    end
                    CMD_PUSH_BACK: begin
                        if (w_full) begin
                            n_st = ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = w_back_slot;
                            n_count = r_count + CW'(1);
                        end
                    end
                    CMD_SEARCH: begin
                        if (w_empty) begin
                            n_st = ST_NOTFOUND;
                        end else begin
                            w_raddr = r_front;
                            n_slot  = w_next_front;
                            n_idx   = '0;
                            n_state = S_SEARCH;
                        end
                    end
                    CMD_POP_FRONT: begin
                        if (w_empty) begin
                            n_st = ST_EMPTY;
                        end else begin
                            w_raddr = r_front;
                            n_front = w_next_front;
                            n_count = r_count - CW'(1);
                            n_state = S_RDWAIT;
                        end
                    end
                    CMD_POP_BACK: begin
                        if (w_empty) begin
                            n_st = ST_EMPTY;
                        end else begin
                            w_raddr = w_tail_slot;
                            n_count = r_count - CW'(1);
                            n_state = S_RDWAIT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RDWAIT: begin
                n_rval  = t_val'(r_rd_data);
                n_state = S_DONE;
            end
            S_SEARCH: begin
                w_raddr = r_slot;
                n_slot  = w_next_slot;
                if (w_hit) begin
                    n_rval  = r_key;
                    n_pos   = r_idx;
                    n_state = S_DONE;
                end else if (w_last) begin
                    n_st    = ST_NOTFOUND;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_key  <= n_key;
        r_idx  <= n_idx;
        r_slot <= n_slot;
        r_st   <= n_st;
        r_rval <= n_rval;
        r_pos  <= n_pos;
        if (w_load) begin
            r_out_st  <= r_st;
            r_out_val <= r_rval;
            r_out_pos <= POS_W'(r_pos);
            r_out_occ <= OCC_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= VAL_W'(r_key);
        end
        r_rd_data <= mem[w_raddr];
    end

    assign i_cmd.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_st;
    assign o_res.result_value = r_out_val;
    assign o_res.position     = r_out_pos;
    assign o_res.occupancy    = r_out_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("Entry count exceeds the deque depth.");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state == S_EXEC))
        else $error("Accepted request did not start execution.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_st == ST_FULL) |-> (r_count == FULL_COUNT))
        else $error("Insert dropped while the deque was not full.");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_st == ST_EMPTY) |-> (r_count == '0))
        else $error("Empty status reported with entries held.");

    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (CW'(r_idx) < r_count))
        else $error("Search index ran past the held entries.");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_valid || o_res.ready))
        else $error("Response overwrote one that was not yet taken.");

endmodule

`default_nettype wire
